// ===== rtl/gsdq_pkg.sv =====
`default_nettype none
package gsdq_pkg;

	localparam int unsigned CoordW  = 16;
	localparam int unsigned ThreshW = 16;
	localparam int unsigned MarginW = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_THRESH_SQ = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MARGIN    = 2'd2;

	localparam logic                RstEnable   = 1'b1;
	localparam logic [ThreshW-1:0]  RstThreshSq = 16'd64;
	localparam logic [MarginW-1:0]  RstMargin   = 8'd2;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	// last direction with a none code in the top bit
	localparam logic [2:0] LAST_NONE = 3'd4;

	typedef struct packed {
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic                     first_sample;
		logic                     last_sample;
	} sample_t;

	typedef struct packed {
		logic       dir_valid;
		logic [1:0] direction;
		logic       stroke_done;
		logic       stayed_in_place;
	} result_t;

	typedef struct packed {
		logic               enable;
		logic [ThreshW-1:0] move_threshold_sq;
		logic [MarginW-1:0] still_margin;
	} cfg_t;

	typedef struct packed {
		logic hit;
		dir_t dir;
	} cls_t;

endpackage
`default_nettype wire

// ===== rtl/gsdq_cfg_regs.sv =====
`default_nettype none
module gsdq_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [gsdq_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [gsdq_pkg::CfgDataW-1:0]   cfg_wdata,
	output gsdq_pkg::cfg_t                       cfg
);

	gsdq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= gsdq_pkg::RstEnable;
			cfg_q.move_threshold_sq <= gsdq_pkg::RstThreshSq;
			cfg_q.still_margin      <= gsdq_pkg::RstMargin;
		end else if (cfg_we) begin
			case (cfg_index)
				gsdq_pkg::REG_ENABLE: begin
					cfg_q.enable <= cfg_wdata[0];
				end
				gsdq_pkg::REG_THRESH_SQ: begin
					cfg_q.move_threshold_sq <= cfg_wdata[gsdq_pkg::ThreshW-1:0];
				end
				gsdq_pkg::REG_MARGIN: begin
					cfg_q.still_margin <= cfg_wdata[gsdq_pkg::MarginW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/gsdq_classify.sv =====
`default_nettype none
module gsdq_classify (
	input  wire logic signed [gsdq_pkg::CoordW-1:0]  x,
	input  wire logic signed [gsdq_pkg::CoordW-1:0]  y,
	input  wire logic signed [gsdq_pkg::CoordW-1:0]  ox,
	input  wire logic signed [gsdq_pkg::CoordW-1:0]  oy,
	input  wire logic [gsdq_pkg::ThreshW-1:0]        thresh_sq,
	output gsdq_pkg::cls_t                           cls
);

	localparam int unsigned DW = gsdq_pkg::CoordW + 1;

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0]        ax, ay;
	logic                 far;
	logic [15:0]          sq_x, sq_y;
	logic [16:0]          dist_sq;

	always_comb begin
		dx = DW'(x) - DW'(ox);
		dy = DW'(y) - DW'(oy);
		ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
		ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
		// any axis at 256 or more already exceeds every threshold
		far  = (ax[DW-1:8] != '0) || (ay[DW-1:8] != '0);
		sq_x = ax[7:0] * ax[7:0];
		sq_y = ay[7:0] * ay[7:0];
		dist_sq = {1'b0, sq_x} + {1'b0, sq_y};

		cls.hit = 1'b0;
		cls.dir = gsdq_pkg::DIR_RIGHT;
		if (far || (dist_sq > {1'b0, thresh_sq})) begin
			if (ax > ay) begin
				cls.hit = 1'b1;
				cls.dir = dx[DW-1] ? gsdq_pkg::DIR_LEFT : gsdq_pkg::DIR_RIGHT;
			end else if (ay > ax) begin
				cls.hit = 1'b1;
				cls.dir = dy[DW-1] ? gsdq_pkg::DIR_UP : gsdq_pkg::DIR_DOWN;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gesture_stroke_direction_quantizer_core.sv =====
// channel  dir  handshake                     payload
// sample   in   sample_valid / sample_ready   sample (gsdq_pkg::sample_t)
// result   out  result_valid / result_ready   result (gsdq_pkg::result_t)
// config   in   cfg_we                        cfg_index, cfg_wdata
//
// one beat per cycle sustained while result_ready holds high; a sample passes from the input
// register through classify and update into the result register
// stroke state is updated, only while enabled, on the same edge that loads the result register
// a stalled result holds the input register; a new beat is taken only while it is empty or advancing
// reset sets the config registers to their defaults, clears both valid flags and clears the stroke state
`default_nettype none
module gesture_stroke_direction_quantizer_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_ready,
	input  wire gsdq_pkg::sample_t               sample,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output gsdq_pkg::result_t                    result,
	input  wire logic                            cfg_we,
	input  wire logic [gsdq_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [gsdq_pkg::CfgDataW-1:0]   cfg_wdata
);

	localparam int unsigned CW = gsdq_pkg::CoordW;
	localparam int unsigned BW = CW + 2;

	gsdq_pkg::cfg_t    cfg;
	gsdq_pkg::sample_t smp_s1;
	logic              valid_s1;
	gsdq_pkg::result_t res_q;
	logic              res_valid_q;

	logic signed [CW-1:0] origin_x_q, origin_y_q, start_x_q, start_y_q;
	logic [2:0]           last_dir_q;
	logic                 all_inside_q;

	logic signed [CW-1:0] ox, oy, sx, sy;
	logic [2:0]           last_dir;
	logic                 inside_prev;
	gsdq_pkg::cls_t       cls;
	logic                 adv, emit, in_box, inside_next;
	logic signed [BW-1:0] lo_x, hi_x, lo_y, hi_y, bx, by, bm;
	gsdq_pkg::result_t    res_d;

	gsdq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv          = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			smp_s1 <= sample;
		end
	end

	// stroke start overrides the held state
	always_comb begin
		ox          = smp_s1.first_sample ? smp_s1.pos_x : origin_x_q;
		oy          = smp_s1.first_sample ? smp_s1.pos_y : origin_y_q;
		sx          = smp_s1.first_sample ? smp_s1.pos_x : start_x_q;
		sy          = smp_s1.first_sample ? smp_s1.pos_y : start_y_q;
		last_dir    = smp_s1.first_sample ? gsdq_pkg::LAST_NONE : last_dir_q;
		inside_prev = smp_s1.first_sample ? 1'b1 : all_inside_q;
	end

	gsdq_classify u_cls (
		.x         (smp_s1.pos_x),
		.y         (smp_s1.pos_y),
		.ox        (ox),
		.oy        (oy),
		.thresh_sq (cfg.move_threshold_sq),
		.cls       (cls)
	);

	// half-open click box
	always_comb begin
		bm          = BW'(cfg.still_margin);
		bx          = BW'(smp_s1.pos_x);
		by          = BW'(smp_s1.pos_y);
		lo_x        = BW'(sx) - bm;
		hi_x        = BW'(sx) + bm;
		lo_y        = BW'(sy) - bm;
		hi_y        = BW'(sy) + bm;
		in_box      = (bx >= lo_x) && (bx < hi_x) && (by >= lo_y) && (by < hi_y);
		inside_next = inside_prev && in_box;
		emit        = cls.hit && ({1'b0, cls.dir} != last_dir);

		res_d.stroke_done = smp_s1.last_sample;
		if (cfg.enable) begin
			res_d.dir_valid       = emit;
			res_d.direction       = emit ? cls.dir : gsdq_pkg::DIR_RIGHT;
			res_d.stayed_in_place = smp_s1.last_sample && inside_next;
		end else begin
			res_d.dir_valid       = 1'b0;
			res_d.direction       = gsdq_pkg::DIR_RIGHT;
			res_d.stayed_in_place = smp_s1.last_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			last_dir_q   <= gsdq_pkg::LAST_NONE;
			all_inside_q <= 1'b1;
		end else if (adv && cfg.enable) begin
			origin_x_q   <= cls.hit ? smp_s1.pos_x : ox;
			origin_y_q   <= cls.hit ? smp_s1.pos_y : oy;
			start_x_q    <= sx;
			start_y_q    <= sy;
			last_dir_q   <= cls.hit ? {1'b0, cls.dir} : last_dir;
			all_inside_q <= inside_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_stayed_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.stroke_done |-> !result.stayed_in_place)
		else $error("stayed_in_place without stroke_done");

	a_dir_zero_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.dir_valid |-> result.direction == gsdq_pkg::DIR_RIGHT)
		else $error("direction not zero without dir_valid");

	a_emit_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dir_valid |-> last_dir_q == {1'b0, result.direction})
		else $error("emitted direction differs from tracked direction");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !result_ready |=> valid_s1 && $stable(smp_s1))
		else $error("input register lost a beat during a stall");

endmodule
`default_nettype wire

// ===== dv/gsdq_stroke_checker.sv =====
`default_nettype none
module gsdq_stroke_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	input  wire logic                          sample_ready,
	input  wire gsdq_pkg::sample_t             sample,
	input  wire logic                          result_valid,
	input  wire logic                          result_ready,
	input  wire gsdq_pkg::result_t             result,
	input  wire logic                          cfg_we,
	input  wire logic [gsdq_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [gsdq_pkg::CfgDataW-1:0] cfg_wdata,
	output int                                 pending,
	output int                                 mismatches
);

	gsdq_pkg::cfg_t                     cfg;
	logic signed [gsdq_pkg::CoordW-1:0] org_x, org_y, st_x, st_y;
	logic [2:0]                         prev_dir;
	logic                               inside_so_far;
	gsdq_pkg::result_t                  awaited_results[$];
	int                                 bad_count;

	task automatic quantize_sample(input gsdq_pkg::sample_t s, output gsdq_pkg::result_t r);
		logic signed [gsdq_pkg::CoordW:0]  dx, dy;
		logic [gsdq_pkg::CoordW:0]         ax, ay;
		logic [2*gsdq_pkg::CoordW+2:0]     dist_sq;
		logic                              hit;
		gsdq_pkg::dir_t                    d;
		int                                m, px, py;
		r = '0;
		r.stroke_done = s.last_sample;
		if (!cfg.enable) begin
			r.stayed_in_place = s.last_sample;
			return;
		end
		if (s.first_sample) begin
			org_x = s.pos_x;
			org_y = s.pos_y;
			st_x = s.pos_x;
			st_y = s.pos_y;
			prev_dir = gsdq_pkg::LAST_NONE;
			inside_so_far = 1'b1;
		end
		dx = s.pos_x - org_x;
		dy = s.pos_y - org_y;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		dist_sq = ax * ax + ay * ay;
		hit = 1'b1;
		d = gsdq_pkg::DIR_RIGHT;
		if (dist_sq <= cfg.move_threshold_sq)
			hit = 1'b0;
		else if (dx > 0 && ax > ay)
			d = gsdq_pkg::DIR_RIGHT;
		else if (dx < 0 && ax > ay)
			d = gsdq_pkg::DIR_LEFT;
		else if (dy > 0 && ay > ax)
			d = gsdq_pkg::DIR_DOWN;
		else if (dy < 0 && ay > ax)
			d = gsdq_pkg::DIR_UP;
		else
			hit = 1'b0;
		if (hit) begin
			if ({1'b0, d} != prev_dir) begin
				prev_dir = {1'b0, d};
				r.dir_valid = 1'b1;
				r.direction = d;
			end
			org_x = s.pos_x;
			org_y = s.pos_y;
		end
		// half-open click box around the stroke start
		m = int'(cfg.still_margin);
		px = int'(s.pos_x);
		py = int'(s.pos_y);
		if (!(px >= int'(st_x) - m && px < int'(st_x) + m &&
		      py >= int'(st_y) - m && py < int'(st_y) + m))
			inside_so_far = 1'b0;
		if (s.last_sample)
			r.stayed_in_place = inside_so_far;
	endtask

	always @(posedge clk or negedge arst_n) begin
		gsdq_pkg::result_t want;
		if (!arst_n) begin
			cfg.enable = gsdq_pkg::RstEnable;
			cfg.move_threshold_sq = gsdq_pkg::RstThreshSq;
			cfg.still_margin = gsdq_pkg::RstMargin;
			org_x = '0;
			org_y = '0;
			st_x = '0;
			st_y = '0;
			prev_dir = gsdq_pkg::LAST_NONE;
			inside_so_far = 1'b1;
			awaited_results.delete();
			bad_count = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gsdq_pkg::REG_ENABLE:
						cfg.enable = cfg_wdata[0];
					gsdq_pkg::REG_THRESH_SQ:
						cfg.move_threshold_sq = cfg_wdata[gsdq_pkg::ThreshW-1:0];
					gsdq_pkg::REG_MARGIN:
						cfg.still_margin = cfg_wdata[gsdq_pkg::MarginW-1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					if (bad_count < 10)
						$display("result beat with nothing outstanding: %b", result);
					bad_count++;
				end else begin
					want = awaited_results.pop_front();
					if (result.dir_valid !== want.dir_valid ||
					    result.direction !== want.direction ||
					    result.stroke_done !== want.stroke_done ||
					    result.stayed_in_place !== want.stayed_in_place) begin
						if (bad_count < 10) begin
							$display("result mismatch: exp valid %b dir %0d done %b still %b",
								want.dir_valid, want.direction, want.stroke_done,
								want.stayed_in_place);
							$display("                 got valid %b dir %0d done %b still %b",
								result.dir_valid, result.direction,
								result.stroke_done, result.stayed_in_place);
						end
						bad_count++;
					end
				end
			end
			if (sample_valid && sample_ready) begin
				quantize_sample(sample, want);
				awaited_results.insert(awaited_results.size(), want);
			end
			pending <= awaited_results.size();
			mismatches <= bad_count;
		end
	end

endmodule
`default_nettype wire

// ===== dv/gesture_stroke_direction_quantizer_core_tb.sv =====
`default_nettype none
module gesture_stroke_direction_quantizer_core_tb;

	localparam int StallLimit = 2000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	gsdq_pkg::sample_t             sample = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	gsdq_pkg::result_t             result;
	logic                          cfg_we = 1'b0;
	logic [gsdq_pkg::CfgIdxW-1:0]  cfg_index = gsdq_pkg::REG_ENABLE;
	logic [gsdq_pkg::CfgDataW-1:0] cfg_wdata = '0;
	int                            pending, mismatches;
	int                            send_idle = 33;
	int                            recv_idle = 53;
	int                            quiet_cycles = 0;

	gesture_stroke_direction_quantizer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	gsdq_stroke_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.pending      (pending),
		.mismatches   (mismatches)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) result_ready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("gesture_stroke_direction_quantizer_core_tb: errors");
			$finish;
		end
	end

	function automatic int clip16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic gsdq_pkg::sample_t point(input int x, input int y, input logic f,
			input logic l);
		gsdq_pkg::sample_t s;
		s.pos_x = 16'(clip16(x));
		s.pos_y = 16'(clip16(y));
		s.first_sample = f;
		s.last_sample = l;
		return s;
	endfunction

	task automatic push_sample(input gsdq_pkg::sample_t s);
		while ($urandom_range(99) < send_idle) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
	endtask

	// hold off until every outstanding beat has come back
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_regs(input logic en, input logic [gsdq_pkg::ThreshW-1:0] thr,
			input logic [gsdq_pkg::MarginW-1:0] m);
		cfg_we <= 1'b1;
		cfg_index <= gsdq_pkg::REG_ENABLE;
		cfg_wdata <= gsdq_pkg::CfgDataW'(en);
		@(posedge clk);
		cfg_index <= gsdq_pkg::REG_THRESH_SQ;
		cfg_wdata <= gsdq_pkg::CfgDataW'(thr);
		@(posedge clk);
		cfg_index <= gsdq_pkg::REG_MARGIN;
		cfg_wdata <= gsdq_pkg::CfgDataW'(m);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_stroke(input int reach, output int sent);
		int len, x, y, k, step;
		logic opened, closed;
		len = $urandom_range(1, 12);
		opened = ($urandom_range(9) != 0);
		closed = ($urandom_range(9) != 0);
		if ($urandom_range(9) < 7) begin
			x = int'($urandom_range(2000)) - 1000;
			y = int'($urandom_range(2000)) - 1000;
		end else begin
			x = int'($urandom_range(65535)) - 32768;
			y = int'($urandom_range(65535)) - 32768;
		end
		for (k = 0; k < len; k++) begin
			if (k > 0) begin
				step = int'($urandom_range(2 * reach)) - reach;
				case ($urandom_range(7))
					0, 1: begin
						x += int'($urandom_range(6)) - 3;
						y += int'($urandom_range(6)) - 3;
					end
					2: x += step;
					3: y += step;
					4: begin
						x += step;
						y += $urandom_range(1) ? step : -step;
					end
					5: begin
						x = int'($urandom_range(65535)) - 32768;
						y = int'($urandom_range(65535)) - 32768;
					end
					default: begin
						x += step;
						y += int'($urandom_range(2 * reach)) - reach;
					end
				endcase
				x = clip16(x);
				y = clip16(y);
			end
			push_sample(point(x, y, opened && k == 0, closed && k == len - 1));
		end
		sent = len;
	endtask

	initial begin
		int seg, quota, reach, done, n;
		logic en;
		logic [gsdq_pkg::ThreshW-1:0] thr;
		logic [gsdq_pkg::MarginW-1:0] margin;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strokes at the reset settings, then disabled, then with a zero margin
		push_sample(point(10, 0, 1'b0, 1'b0));
		push_sample(point(100, 100, 1'b1, 1'b0));
		push_sample(point(110, 100, 1'b0, 1'b0));
		push_sample(point(120, 100, 1'b0, 1'b0));
		push_sample(point(120, 101, 1'b0, 1'b0));
		push_sample(point(110, 110, 1'b0, 1'b0));
		push_sample(point(110, 100, 1'b0, 1'b0));
		push_sample(point(110, 115, 1'b0, 1'b0));
		push_sample(point(110, 100, 1'b0, 1'b1));
		push_sample(point(5, 5, 1'b1, 1'b0));
		push_sample(point(6, 6, 1'b0, 1'b0));
		push_sample(point(3, 3, 1'b0, 1'b1));
		push_sample(point(0, 0, 1'b1, 1'b0));
		push_sample(point(1, -2, 1'b0, 1'b0));
		push_sample(point(2, 0, 1'b0, 1'b1));
		push_sample(point(0, 0, 1'b1, 1'b1));
		push_sample(point(-32768, -32768, 1'b1, 1'b0));
		push_sample(point(32767, 32767, 1'b0, 1'b0));
		push_sample(point(32767, -32768, 1'b0, 1'b0));
		push_sample(point(-32768, 32767, 1'b0, 1'b0));
		push_sample(point(-32768, -32768, 1'b0, 1'b0));
		push_sample(point(-32768, 32767, 1'b0, 1'b1));
		settle();
		program_regs(1'b0, 16'd64, 8'd2);
		push_sample(point(50, 50, 1'b1, 1'b0));
		push_sample(point(60, 50, 1'b0, 1'b1));
		settle();
		program_regs(1'b1, 16'd64, 8'd0);
		push_sample(point(0, 0, 1'b1, 1'b1));
		settle();

		for (seg = 0; seg < 12; seg++) begin
			case (seg / 4)
				0: begin send_idle = 33; recv_idle = 53; end
				1: begin send_idle = 53; recv_idle = 33; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			en = 1'b1;
			quota = 150;
			case (seg)
				0:  begin thr = 16'd64;    margin = 8'd2;   reach = 20;  end
				1:  begin thr = 16'd0;     margin = 8'd0;   reach = 5;   end
				2:  begin thr = 16'd65535; margin = 8'd255; reach = 400; end
				3:  begin
					en = 1'b0;
					thr = 16'd100;
					margin = 8'd10;
					reach = 20;
					quota = 40;
				end
				4:  begin thr = 16'd1;     margin = 8'd1;   reach = 4;   end
				5:  begin
					thr = 16'($urandom_range(65535));
					margin = 8'($urandom_range(255));
					reach = 300;
				end
				6:  begin thr = 16'd16;    margin = 8'd3;   reach = 8;   end
				7:  begin thr = 16'd4096;  margin = 8'd40;  reach = 120; end
				8:  begin thr = 16'd65535; margin = 8'd0;   reach = 300; end
				9:  begin thr = 16'd0;     margin = 8'd255; reach = 10;  end
				10: begin
					thr = 16'($urandom_range(1024));
					margin = 8'($urandom_range(8));
					reach = 40;
				end
				default: begin thr = 16'd64; margin = 8'd2; reach = 20; end
			endcase
			program_regs(en, thr, margin);
			done = 0;
			while (done < quota) begin
				if ($urandom_range(9) == 0) begin
					push_sample(point(int'($urandom_range(65535)) - 32768,
						int'($urandom_range(65535)) - 32768,
						1'($urandom_range(1)), 1'($urandom_range(1))));
					done++;
				end else begin
					send_stroke(reach, n);
					done += n;
				end
			end
			settle();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("gesture_stroke_direction_quantizer_core_tb: clean");
		else
			$display("gesture_stroke_direction_quantizer_core_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/gsdq_pkg.sv
rtl/gsdq_cfg_regs.sv
rtl/gsdq_classify.sv
rtl/gesture_stroke_direction_quantizer_core.sv
dv/gsdq_stroke_checker.sv
dv/gesture_stroke_direction_quantizer_core_tb.sv
